// ----- rtl/core/dlh_pkg.sv -----
`default_nettype none
package dlh_pkg;

  localparam int MAX_LINES_DEF = 64;
  localparam int LINE_COUNT_W  = 7;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic signed [31:0] SLOPE_LIM = 32'sh7fff_ffff;
  localparam logic signed [63:0] ICPT_LIM  = 64'sh4000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [63:0] intercept;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  typedef struct packed {
    logic               op;
    logic signed [31:0] slope;
    logic signed [63:0] intercept;
    logic signed [31:0] point;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0]        value;
    logic                      empty_flag;
    logic                      full_flag;
    logic [LINE_COUNT_W-1:0]   line_count;
  } out_item_t;

  // Breakpoint test request: is lj useless between li and lk (ascending slopes)?
  typedef struct packed {
    logic  start;
    line_t li;
    line_t lj;
    line_t lk;
  } cmp_req_t;

  typedef struct packed {
    logic done;
    logic useless;
  } cmp_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/dynamic_line_hull_max_query.sv -----
// A query reads one table word per cycle for the n stored lines and keeps the best value.
// An add reads the table word by word to find its slot p, runs each breakpoint test
// on the shared 32x32 multiplier, and then moves the upper table part.
// One item at a time; results are registered, shown for one cycle, never stalled.
// Reset clears the line count and min_mode; table words stay undefined until written.
`default_nettype none
module dynamic_line_hull_max_query #(
  parameter int MAX_LINES = dlh_pkg::MAX_LINES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire dlh_pkg::in_item_t  in_data,
  output      logic               out_strobe,
  output      dlh_pkg::out_item_t out_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic               cfg_min_mode
);

  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_QRY   = 5'd1;
  localparam logic [4:0] S_FRD   = 5'd2;
  localparam logic [4:0] S_FEV   = 5'd3;
  localparam logic [4:0] S_FDONE = 5'd4;
  localparam logic [4:0] S_NRL   = 5'd5;
  localparam logic [4:0] S_NRR   = 5'd6;
  localparam logic [4:0] S_NCAP  = 5'd7;
  localparam logic [4:0] S_NWT   = 5'd8;
  localparam logic [4:0] S_LCHK  = 5'd9;
  localparam logic [4:0] S_LRD1  = 5'd10;
  localparam logic [4:0] S_LRD2  = 5'd11;
  localparam logic [4:0] S_LCAP  = 5'd12;
  localparam logic [4:0] S_LWT   = 5'd13;
  localparam logic [4:0] S_RCHK  = 5'd14;
  localparam logic [4:0] S_RRD1  = 5'd15;
  localparam logic [4:0] S_RRD2  = 5'd16;
  localparam logic [4:0] S_RCAP  = 5'd17;
  localparam logic [4:0] S_RWT   = 5'd18;
  localparam logic [4:0] S_WB    = 5'd19;
  localparam logic [4:0] S_SH    = 5'd20;
  localparam logic [4:0] S_INS   = 5'd21;

  logic [4:0]         state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               min_mode_r, min_mode_nxt;
  dlh_pkg::line_t     new_r, new_nxt, hold_r, hold_nxt;
  logic signed [31:0] pnt_r, pnt_nxt;
  logic [CW-1:0]      q_r, q_nxt, a_r, a_nxt, c_r, c_nxt, nn_r, nn_nxt;
  logic               keep_r, keep_nxt, eq_r, eq_nxt;
  logic signed [63:0] eqb_r, eqb_nxt;
  logic [CW-1:0]      sh_dst_r, sh_dst_nxt, sh_rem_r, sh_rem_nxt;
  logic [AW-1:0]      sh_wa_r, sh_wa_nxt;
  logic               sh_pend_r, sh_pend_nxt, sh_left_r, sh_left_nxt;
  logic               rv1_r, rv1_nxt, pv2_r, pv2_nxt, have_r, have_nxt;
  logic signed [63:0] prod_r, prod_nxt, pb_r, pb_nxt, best_r, best_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  dlh_pkg::out_item_t out_r, out_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  dlh_pkg::line_t     ram_wdata, rd_line;
  dlh_pkg::cmp_req_t  cmp_req;
  dlh_pkg::cmp_rsp_t  cmp_rsp;

  logic signed [31:0] s_sat;
  logic signed [63:0] b_sat, qv;
  logic [CW-1:0]      q_p1, a_m1, a_m2, c_p1, c_eq, n_m1;
  logic [CW:0]        ak, nn_calc;

  assign q_p1 = q_r + CW'(1);
  assign a_m1 = a_r - CW'(1);
  assign a_m2 = a_r - CW'(2);
  assign c_p1 = c_r + CW'(1);
  assign c_eq = a_r + CW'(eq_r);
  assign n_m1 = cnt_r - CW'(1);
  assign ak   = {1'b0, a_r} + (CW+1)'(keep_r);
  assign nn_calc = ak + {1'b0, cnt_r} - {1'b0, c_r};
  assign qv   = prod_r + pb_r;

  always_comb begin
    s_sat = in_data.slope;
    if (in_data.slope < -dlh_pkg::SLOPE_LIM) begin
      s_sat = -dlh_pkg::SLOPE_LIM;
    end
    b_sat = in_data.intercept;
    if (in_data.intercept > dlh_pkg::ICPT_LIM) begin
      b_sat = dlh_pkg::ICPT_LIM;
    end else if (in_data.intercept < -dlh_pkg::ICPT_LIM) begin
      b_sat = -dlh_pkg::ICPT_LIM;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    min_mode_nxt = min_mode_r;
    new_nxt      = new_r;
    hold_nxt     = hold_r;
    pnt_nxt      = pnt_r;
    q_nxt        = q_r;
    a_nxt        = a_r;
    c_nxt        = c_r;
    nn_nxt       = nn_r;
    keep_nxt     = keep_r;
    eq_nxt       = eq_r;
    eqb_nxt      = eqb_r;
    sh_dst_nxt   = sh_dst_r;
    sh_rem_nxt   = sh_rem_r;
    sh_wa_nxt    = sh_wa_r;
    sh_left_nxt  = sh_left_r;
    sh_pend_nxt  = 1'b0;
    rv1_nxt      = 1'b0;
    pv2_nxt      = rv1_r;
    prod_nxt     = prod_r;
    pb_nxt       = pb_r;
    best_nxt     = best_r;
    have_nxt     = have_r;
    out_strobe_nxt = 1'b0;
    out_nxt      = out_r;
    ram_raddr    = '0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = new_r;
    cmp_req      = '0;

    if (cfg_valid) begin
      min_mode_nxt = cfg_min_mode;
    end

    // Query pipeline: read word, then multiply, then add and keep the best.
    if (rv1_r) begin
      prod_nxt = rd_line.slope * pnt_r;
      pb_nxt   = rd_line.intercept;
    end
    if (pv2_r && (!have_r || qv > best_r)) begin
      best_nxt = qv;
      have_nxt = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          new_nxt.slope     = min_mode_r ? -s_sat : s_sat;
          new_nxt.intercept = min_mode_r ? -b_sat : b_sat;
          pnt_nxt  = in_data.point;
          q_nxt    = '0;
          have_nxt = 1'b0;
          eq_nxt   = 1'b0;
          a_nxt    = '0;
          if (in_data.op == dlh_pkg::OP_QUERY) begin
            if (cnt_r == '0) begin
              out_strobe_nxt      = 1'b1;
              out_nxt.value       = '0;
              out_nxt.empty_flag  = 1'b1;
              out_nxt.full_flag   = 1'b0;
              out_nxt.line_count  = dlh_pkg::LINE_COUNT_W'(cnt_r);
            end else begin
              state_nxt = S_QRY;
            end
          end else if (cnt_r == '0) begin
            state_nxt = S_FDONE;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_QRY: begin
        if (q_r != cnt_r) begin
          ram_raddr = q_r[AW-1:0];
          q_nxt     = q_p1;
          rv1_nxt   = 1'b1;
        end else if (!rv1_r && !pv2_r) begin
          out_strobe_nxt      = 1'b1;
          out_nxt.value       = min_mode_r ? -best_r : best_r;
          out_nxt.empty_flag  = 1'b0;
          out_nxt.full_flag   = 1'b0;
          out_nxt.line_count  = dlh_pkg::LINE_COUNT_W'(cnt_r);
          state_nxt = S_IDLE;
        end
      end
      S_FRD: begin
        ram_raddr = q_r[AW-1:0];
        state_nxt = S_FEV;
      end
      S_FEV: begin
        if (rd_line.slope < new_r.slope) begin
          q_nxt = q_p1;
          if (q_p1 == cnt_r) begin
            a_nxt     = cnt_r;
            state_nxt = S_FDONE;
          end else begin
            state_nxt = S_FRD;
          end
        end else begin
          a_nxt     = q_r;
          eq_nxt    = (rd_line.slope == new_r.slope);
          eqb_nxt   = rd_line.intercept;
          state_nxt = S_FDONE;
        end
      end
      S_FDONE: begin
        keep_nxt = 1'b1;
        c_nxt    = c_eq;
        if (eq_r && !(eqb_r < new_r.intercept)) begin
          // An equal-slope line at least as high is already stored: drop the new one.
          out_strobe_nxt      = 1'b1;
          out_nxt.value       = '0;
          out_nxt.empty_flag  = 1'b0;
          out_nxt.full_flag   = 1'b0;
          out_nxt.line_count  = dlh_pkg::LINE_COUNT_W'(cnt_r);
          state_nxt = S_IDLE;
        end else if (a_r != '0 && c_eq < cnt_r) begin
          state_nxt = S_NRL;
        end else begin
          state_nxt = S_LCHK;
        end
      end
      S_NRL: begin
        ram_raddr = a_m1[AW-1:0];
        state_nxt = S_NRR;
      end
      S_NRR: begin
        hold_nxt  = rd_line;
        ram_raddr = c_r[AW-1:0];
        state_nxt = S_NCAP;
      end
      S_NCAP: begin
        cmp_req.start = 1'b1;
        cmp_req.li    = hold_r;
        cmp_req.lj    = new_r;
        cmp_req.lk    = rd_line;
        state_nxt     = S_NWT;
      end
      S_NWT: begin
        if (cmp_rsp.done) begin
          if (cmp_rsp.useless) begin
            keep_nxt  = 1'b0;
            state_nxt = S_WB;
          end else begin
            state_nxt = S_LCHK;
          end
        end
      end
      S_LCHK: begin
        state_nxt = (a_r >= CW'(2)) ? S_LRD1 : S_RCHK;
      end
      S_LRD1: begin
        ram_raddr = a_m1[AW-1:0];
        state_nxt = S_LRD2;
      end
      S_LRD2: begin
        hold_nxt  = rd_line;
        ram_raddr = a_m2[AW-1:0];
        state_nxt = S_LCAP;
      end
      S_LCAP: begin
        cmp_req.start = 1'b1;
        cmp_req.li    = rd_line;
        cmp_req.lj    = hold_r;
        cmp_req.lk    = new_r;
        state_nxt     = S_LWT;
      end
      S_LWT: begin
        if (cmp_rsp.done) begin
          if (cmp_rsp.useless) begin
            a_nxt     = a_m1;
            state_nxt = S_LCHK;
          end else begin
            state_nxt = S_RCHK;
          end
        end
      end
      S_RCHK: begin
        state_nxt = (({1'b0, c_r} + (CW+1)'(1)) < {1'b0, cnt_r}) ? S_RRD1 : S_WB;
      end
      S_RRD1: begin
        ram_raddr = c_r[AW-1:0];
        state_nxt = S_RRD2;
      end
      S_RRD2: begin
        hold_nxt  = rd_line;
        ram_raddr = c_p1[AW-1:0];
        state_nxt = S_RCAP;
      end
      S_RCAP: begin
        cmp_req.start = 1'b1;
        cmp_req.li    = new_r;
        cmp_req.lj    = hold_r;
        cmp_req.lk    = rd_line;
        state_nxt     = S_RWT;
      end
      S_RWT: begin
        if (cmp_rsp.done) begin
          if (cmp_rsp.useless) begin
            c_nxt     = c_p1;
            state_nxt = S_RCHK;
          end else begin
            state_nxt = S_WB;
          end
        end
      end
      S_WB: begin
        if (keep_r && a_r == c_r && cnt_r == CW'(MAX_LINES)) begin
          out_strobe_nxt      = 1'b1;
          out_nxt.value       = '0;
          out_nxt.empty_flag  = 1'b0;
          out_nxt.full_flag   = 1'b1;
          out_nxt.line_count  = dlh_pkg::LINE_COUNT_W'(cnt_r);
          state_nxt = S_IDLE;
        end else begin
          // The kept lines above the new one move to start right after it, or at its slot if it is dropped.
          nn_nxt     = nn_calc[CW-1:0];
          sh_rem_nxt = cnt_r - c_r;
          if ({1'b0, c_r} > ak) begin
            sh_left_nxt = 1'b1;
            q_nxt       = c_r;
            sh_dst_nxt  = ak[CW-1:0];
          end else if ({1'b0, c_r} < ak) begin
            sh_left_nxt = 1'b0;
            q_nxt       = n_m1;
            sh_dst_nxt  = cnt_r;
          end else begin
            sh_rem_nxt  = '0;
          end
          state_nxt = S_SH;
        end
      end
      S_SH: begin
        if (sh_pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = sh_wa_r;
          ram_wdata = rd_line;
        end
        if (sh_rem_r != '0) begin
          ram_raddr   = q_r[AW-1:0];
          sh_pend_nxt = 1'b1;
          sh_wa_nxt   = sh_dst_r[AW-1:0];
          sh_rem_nxt  = sh_rem_r - CW'(1);
          q_nxt       = sh_left_r ? q_r + CW'(1) : q_r - CW'(1);
          sh_dst_nxt  = sh_left_r ? sh_dst_r + CW'(1) : sh_dst_r - CW'(1);
        end else if (!sh_pend_r) begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        if (keep_r) begin
          ram_we    = 1'b1;
          ram_waddr = a_r[AW-1:0];
          ram_wdata = new_r;
        end
        cnt_nxt             = nn_r;
        out_strobe_nxt      = 1'b1;
        out_nxt.value       = '0;
        out_nxt.empty_flag  = 1'b0;
        out_nxt.full_flag   = 1'b0;
        out_nxt.line_count  = dlh_pkg::LINE_COUNT_W'(nn_r);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      min_mode_r   <= 1'b0;
      sh_pend_r    <= 1'b0;
      rv1_r        <= 1'b0;
      pv2_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      min_mode_r   <= min_mode_nxt;
      sh_pend_r    <= sh_pend_nxt;
      rv1_r        <= rv1_nxt;
      pv2_r        <= pv2_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r     <= new_nxt;
    hold_r    <= hold_nxt;
    pnt_r     <= pnt_nxt;
    q_r       <= q_nxt;
    a_r       <= a_nxt;
    c_r       <= c_nxt;
    nn_r      <= nn_nxt;
    keep_r    <= keep_nxt;
    eq_r      <= eq_nxt;
    eqb_r     <= eqb_nxt;
    sh_dst_r  <= sh_dst_nxt;
    sh_rem_r  <= sh_rem_nxt;
    sh_wa_r   <= sh_wa_nxt;
    sh_left_r <= sh_left_nxt;
    prod_r    <= prod_nxt;
    pb_r      <= pb_nxt;
    best_r    <= best_nxt;
    have_r    <= have_nxt;
    out_r     <= out_nxt;
  end

  dlh_ram #(
    .WIDTH (dlh_pkg::LINE_W),
    .DEPTH (MAX_LINES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_line)
  );

  dlh_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cmp_req),
    .rsp   (cmp_rsp)
  );

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_LINES))
    else $error("line count exceeds table depth");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SH || state_r == S_INS))
    else $error("table written outside the write-back phase");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_r.full_flag) |-> (cnt_r == $past(cnt_r)))
    else $error("rejected add changed the line count");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe_r))
    else $error("accepted word neither in progress nor answered");

  a_cmp_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_rsp.done |-> (state_r == S_NWT || state_r == S_LWT || state_r == S_RWT))
    else $error("breakpoint test finished while nobody waits");

endmodule
`default_nettype wire

// ----- rtl/core/dlh_ram.sv -----
`default_nettype none
module dlh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/dlh_cmp.sv -----
`default_nettype none
module dlh_cmp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dlh_pkg::cmp_req_t req,
  output      dlh_pkg::cmp_rsp_t rsp
);

  // Tests (bi - bk) * (mj - mi) <= (bi - bj) * (mk - mi) exactly. Each product is a
  // 64-bit magnitude times a 32-bit slope gap, built from two 32x32 partial products.
  logic        run_r, pv_r, done_r, useless_r;
  logic [2:0]  cnt_r;
  logic [1:0]  sel_r;
  logic [63:0] mag1_r, mag2_r, prod_r;
  logic        neg1_r, neg2_r;
  logic [31:0] f1_r, f2_r;
  logic [95:0] acc1_r, acc2_r;

  logic signed [32:0] dj, dk;
  logic signed [64:0] d1, d2, d1_abs, d2_abs;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mag_sel;
  logic [95:0]        term;
  logic signed [96:0] p1, p2;

  assign dj = {req.lj.slope[31], req.lj.slope} - {req.li.slope[31], req.li.slope};
  assign dk = {req.lk.slope[31], req.lk.slope} - {req.li.slope[31], req.li.slope};
  assign d1 = {req.li.intercept[63], req.li.intercept} - {req.lk.intercept[63], req.lk.intercept};
  assign d2 = {req.li.intercept[63], req.li.intercept} - {req.lj.intercept[63], req.lj.intercept};
  assign d1_abs = d1[64] ? -d1 : d1;
  assign d2_abs = d2[64] ? -d2 : d2;

  assign mag_sel = cnt_r[1] ? mag2_r : mag1_r;
  assign mul_a   = cnt_r[0] ? mag_sel[63:32] : mag_sel[31:0];
  assign mul_b   = cnt_r[1] ? f2_r : f1_r;
  assign term    = sel_r[0] ? {prod_r, 32'b0} : {32'b0, prod_r};

  assign p1 = neg1_r ? -$signed({1'b0, acc1_r}) : $signed({1'b0, acc1_r});
  assign p2 = neg2_r ? -$signed({1'b0, acc2_r}) : $signed({1'b0, acc2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        pv_r  <= 1'b0;
        cnt_r <= '0;
      end else if (run_r) begin
        pv_r  <= (cnt_r < 3'd4);
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mag1_r <= d1_abs[63:0];
      mag2_r <= d2_abs[63:0];
      neg1_r <= d1[64];
      neg2_r <= d2[64];
      f1_r   <= dj[31:0];
      f2_r   <= dk[31:0];
      acc1_r <= '0;
      acc2_r <= '0;
    end else if (run_r) begin
      if (cnt_r < 3'd4) begin
        prod_r <= mul_a * mul_b;
        sel_r  <= cnt_r[1:0];
      end
      if (pv_r) begin
        if (sel_r[1]) begin
          acc2_r <= acc2_r + term;
        end else begin
          acc1_r <= acc1_r + term;
        end
      end
      if (cnt_r == 3'd5) begin
        useless_r <= (p1 <= p2);
      end
    end
  end

  assign rsp.done    = done_r;
  assign rsp.useless = useless_r;

endmodule
`default_nettype wire
